### rtl/core/gmi_pkg.sv
// gmi_pkg: shared types and codes of the grid interpolator
// payload structs, datapath command and status structs, field and register codes
// no dependencies
`default_nettype none

package gmi_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PZ  = 2'd3;

  // item functions
  localparam logic [1:0] FUNC_AXIS  = 2'd0;
  localparam logic [1:0] FUNC_GRID  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam int GRID_DEPTH = 4096;
  localparam int GRID_AW    = 12;

  typedef struct packed {
    logic [1:0]         func;
    logic [1:0]         axis;
    logic [11:0]        index;
    logic signed [31:0] data;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
  } gmi_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } gmi_out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_RD_FIRST,
    OP_RD_LAST,
    OP_EDGE,
    OP_RD_MID,
    OP_CMP,
    OP_RD_X0,
    OP_RD_X1,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_GRID_RD,
    OP_GRID_WR,
    OP_L_RDA,
    OP_L_RDB,
    OP_L_DIFF,
    OP_L_MLO,
    OP_L_MHI,
    OP_L_SUM,
    OP_L_FIN,
    OP_OUT
  } gmi_op_t;

  typedef struct packed {
    gmi_op_t op;
  } gmi_cmd_t;

  typedef struct packed {
    logic query;
    logic dim_zero;
    logic open;
    logic div_last;
    logic last_axis;
    logic last_corner;
    logic last_lerp;
    logic out_free;
  } gmi_st_t;

endpackage

`default_nettype wire

### rtl/core/gmi_ctrl.sv
// gmi_ctrl: sequencer of the grid interpolator
// steps the datapath through search, divide, grid fetch and blend; uses gmi_pkg
`default_nettype none

module gmi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gmi_pkg::gmi_st_t st,
  output gmi_pkg::gmi_cmd_t cmd
);
  import gmi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_FIRST, S_RD_LAST, S_EDGE, S_SRCH, S_CMP, S_RD_X1,
    S_DIV_INIT, S_DIV, S_DIV_STORE, S_G_RD, S_G_WR,
    S_L_RA, S_L_RB, S_L_DIFF, S_L_MLO, S_L_MHI, S_L_SUM, S_L_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (st.query) begin
            state_nxt = st.dim_zero ? S_OUT : S_RD_FIRST;
          end
        end
      end
      S_RD_FIRST: begin
        cmd.op    = OP_RD_FIRST;
        state_nxt = S_RD_LAST;
      end
      S_RD_LAST: begin
        cmd.op    = OP_RD_LAST;
        state_nxt = S_EDGE;
      end
      S_EDGE: begin
        cmd.op    = OP_EDGE;
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (st.open) begin
          cmd.op    = OP_RD_MID;
          state_nxt = S_CMP;
        end else begin
          cmd.op    = OP_RD_X0;
          state_nxt = S_RD_X1;
        end
      end
      S_CMP: begin
        cmd.op    = OP_CMP;
        state_nxt = S_SRCH;
      end
      S_RD_X1: begin
        cmd.op    = OP_RD_X1;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (st.div_last) begin
          state_nxt = S_DIV_STORE;
        end
      end
      S_DIV_STORE: begin
        cmd.op    = OP_DIV_STORE;
        state_nxt = st.last_axis ? S_G_RD : S_RD_FIRST;
      end
      S_G_RD: begin
        cmd.op    = OP_GRID_RD;
        state_nxt = S_G_WR;
      end
      S_G_WR: begin
        cmd.op    = OP_GRID_WR;
        state_nxt = st.last_corner ? S_L_RA : S_G_RD;
      end
      S_L_RA: begin
        cmd.op    = OP_L_RDA;
        state_nxt = S_L_RB;
      end
      S_L_RB: begin
        cmd.op    = OP_L_RDB;
        state_nxt = S_L_DIFF;
      end
      S_L_DIFF: begin
        cmd.op    = OP_L_DIFF;
        state_nxt = S_L_MLO;
      end
      S_L_MLO: begin
        cmd.op    = OP_L_MLO;
        state_nxt = S_L_MHI;
      end
      S_L_MHI: begin
        cmd.op    = OP_L_MHI;
        state_nxt = S_L_SUM;
      end
      S_L_SUM: begin
        cmd.op    = OP_L_SUM;
        state_nxt = S_L_FIN;
      end
      S_L_FIN: begin
        cmd.op    = OP_L_FIN;
        state_nxt = st.last_lerp ? S_OUT : S_L_RA;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/gmi_dp.sv
// gmi_dp: datapath of the grid interpolator
// coordinate and grid stores, search registers, serial divider, blend unit, output register
// uses gmi_pkg; driven by gmi_ctrl
`default_nettype none

module gmi_dp #(
  parameter int MAX_AXIS_POINTS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gmi_pkg::gmi_cmd_t                  cmd,
  output gmi_pkg::gmi_st_t                   st,
  input  gmi_pkg::gmi_in_t                   in_data,
  input  logic                               cfg_we,
  input  logic [gmi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmi_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output gmi_pkg::gmi_out_t                  out_data
);
  import gmi_pkg::*;

  localparam int PW  = $clog2(MAX_AXIS_POINTS);
  localparam int NW  = PW + 1;
  localparam int AXD = 3 * MAX_AXIS_POINTS;
  localparam int AXW = $clog2(AXD);

  // configuration
  logic [1:0] dims_r;
  logic [4:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= 2'd1;
      px_r   <= 5'd2;
      py_r   <= 5'd2;
      pz_r   <= 5'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIM: dims_r <= cfg_data[1:0];
        CFG_PX:  px_r   <= cfg_data;
        CFG_PY:  py_r   <= cfg_data;
        CFG_PZ:  pz_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [NW-1:0] clamp_pts(input logic [4:0] p);
    logic [7:0] pe;
    pe = {3'b000, p};
    if (pe < 8'd2) begin
      return NW'(2);
    end else if (pe > 8'(MAX_AXIS_POINTS)) begin
      return NW'(MAX_AXIS_POINTS);
    end
    return NW'(pe);
  endfunction

  logic [NW-1:0] n0, n1, n2, n_sel;
  assign n0 = clamp_pts(px_r);
  assign n1 = clamp_pts(py_r);
  assign n2 = clamp_pts(pz_r);

  // query state
  logic signed [31:0] qx_r, qy_r, qz_r, q_sel;
  logic [1:0]         d_r;
  logic [PW-1:0]      lo_r, hi_r, mid;
  logic               le0_r;
  logic signed [31:0] x0_r;
  logic [PW-1:0]      pos_r [0:2];
  logic [48:0]        t_mag_r [0:2];
  logic [2:0]         t_neg_r;
  logic [11:0]        sx_r, sy_r;
  logic [2:0]         j_r;
  logic [1:0]         k_r, lv_r;
  logic signed [31:0] res_r;
  logic               sat_r, zero_r;

  always_comb begin
    case (d_r)
      2'd0: begin
        n_sel = n0;
        q_sel = qx_r;
      end
      2'd1: begin
        n_sel = n1;
        q_sel = qy_r;
      end
      default: begin
        n_sel = n2;
        q_sel = qz_r;
      end
    endcase
  end

  assign mid = PW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);

  // coordinate store
  logic signed [31:0] ax_mem [0:AXD-1];
  logic signed [31:0] ax_rdata_r;
  logic [PW-1:0]      ax_idx;
  logic [AXW-1:0]     ax_raddr, ax_waddr;
  logic               ax_we;

  always_comb begin
    case (cmd.op)
      OP_RD_LAST: ax_idx = PW'(n_sel - 1'b1);
      OP_RD_MID:  ax_idx = mid;
      OP_RD_X0:   ax_idx = lo_r;
      OP_RD_X1:   ax_idx = PW'({1'b0, lo_r} + 1'b1);
      default:    ax_idx = '0;
    endcase
  end

  assign ax_raddr = AXW'(int'(d_r) * MAX_AXIS_POINTS + int'(ax_idx));
  assign ax_waddr = AXW'(int'(in_data.axis) * MAX_AXIS_POINTS + int'(in_data.index));
  assign ax_we    = (cmd.op == OP_ACCEPT) && (in_data.func == FUNC_AXIS) &&
                    (in_data.axis != 2'd3) && (in_data.index < 12'(MAX_AXIS_POINTS));

  always_ff @(posedge clk) begin
    if (ax_we) begin
      ax_mem[ax_waddr] <= in_data.data;
    end
    ax_rdata_r <= ax_mem[ax_raddr];
  end

  // grid store
  logic signed [31:0]  gr_mem [0:GRID_DEPTH-1];
  logic signed [31:0]  gr_rdata_r;
  logic [GRID_AW-1:0]  gr_raddr;
  logic [2:0]          kc;
  logic [11:0]         term_x, term_y, term_z;

  // corners are fetched compacted: corner j of the axes in use
  assign kc     = 3'(j_r << (2'd3 - dims_r));
  assign term_x = 12'(12'({1'b0, pos_r[0]} + NW'(kc[2])) * sx_r);
  assign term_y = (dims_r >= 2'd2) ? 12'(12'({1'b0, pos_r[1]} + NW'(kc[1])) * sy_r) : 12'd0;
  assign term_z = (dims_r == 2'd3) ? 12'({1'b0, pos_r[2]} + NW'(kc[0])) : 12'd0;
  assign gr_raddr = term_x + term_y + term_z;

  always_ff @(posedge clk) begin
    if ((cmd.op == OP_ACCEPT) && (in_data.func == FUNC_GRID)) begin
      gr_mem[in_data.index] <= in_data.data;
    end
    gr_rdata_r <= gr_mem[gr_raddr];
  end

  // corner store, reused in place by the blend levels
  logic signed [31:0] cs_mem [0:7];
  logic signed [31:0] cs_rdata_r;
  logic [2:0]         cs_raddr;
  logic signed [31:0] lf_res;

  assign cs_raddr = (cmd.op == OP_L_RDB) ? {k_r, 1'b1} : {k_r, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.op == OP_GRID_WR) begin
      cs_mem[j_r] <= gr_rdata_r;
    end else if (cmd.op == OP_L_FIN) begin
      cs_mem[{1'b0, k_r}] <= lf_res;
    end
    cs_rdata_r <= cs_mem[cs_raddr];
  end

  // weight divider
  logic signed [32:0] num, den;
  logic [31:0]        mn, md;
  logic [48:0]        dv_q_r;
  logic [31:0]        dv_rem_r, dv_den_r;
  logic [5:0]         dv_cnt_r;
  logic               dv_neg_r, dv_zero_r;
  logic [32:0]        rem_sh;

  assign num    = {q_sel[31], q_sel} - {x0_r[31], x0_r};
  assign den    = {ax_rdata_r[31], ax_rdata_r} - {x0_r[31], x0_r};
  assign mn     = num[32] ? 32'(-num) : 32'(num);
  assign md     = den[32] ? 32'(-den) : 32'(den);
  assign rem_sh = {dv_rem_r, dv_q_r[48]};

  // blend unit
  logic signed [31:0] a_r;
  logic [31:0]        ld_mag_r;
  logic               ld_neg_r;
  logic [63:0]        p_lo_r;
  logic [48:0]        p_hi_r;
  logic [33:0]        r_r;
  logic               over_r;
  logic signed [32:0] dd;
  logic [48:0]        t_sel;
  logic [80:0]        prod;
  logic signed [34:0] lf_s, lf_sum;
  logic               lf_sat;

  assign t_sel = t_mag_r[lv_r];
  assign dd    = {cs_rdata_r[31], cs_rdata_r} - {a_r[31], a_r};
  assign prod  = {17'd0, p_lo_r} + {p_hi_r, 32'd0};
  assign lf_s  = ld_neg_r ? -$signed({1'b0, r_r}) : $signed({1'b0, r_r});
  assign lf_sum = {{3{a_r[31]}}, a_r} + lf_s;

  always_comb begin
    lf_sat = 1'b1;
    if (over_r) begin
      lf_res = ld_neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (lf_sum > 35'sd2147483647) begin
      lf_res = 32'sh7fff_ffff;
    end else if (lf_sum < -35'sd2147483648) begin
      lf_res = 32'sh8000_0000;
    end else begin
      lf_res = 32'(lf_sum);
      lf_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        if (in_data.func == FUNC_QUERY) begin
          qx_r   <= in_data.query_x;
          qy_r   <= in_data.query_y;
          qz_r   <= in_data.query_z;
          d_r    <= 2'd0;
          j_r    <= 3'd0;
          k_r    <= 2'd0;
          lv_r   <= dims_r - 2'd1;
          sy_r   <= (dims_r == 2'd3) ? 12'(n2) : 12'd1;
          sx_r   <= (dims_r == 2'd3) ? 12'(12'(n1) * 12'(n2)) :
                    (dims_r == 2'd2) ? 12'(n1) : 12'd1;
          res_r  <= '0;
          sat_r  <= 1'b0;
          zero_r <= 1'b0;
        end
      end
      OP_RD_LAST: begin
        le0_r <= (q_sel <= ax_rdata_r);
      end
      OP_EDGE: begin
        if (le0_r) begin
          lo_r <= '0;
          hi_r <= PW'(1);
        end else if (q_sel >= ax_rdata_r) begin
          lo_r <= PW'(n_sel - 2'd2);
          hi_r <= PW'(n_sel - 1'b1);
        end else begin
          lo_r <= '0;
          hi_r <= PW'(n_sel - 1'b1);
        end
      end
      OP_CMP: begin
        if (q_sel < ax_rdata_r) begin
          hi_r <= mid;
        end else begin
          lo_r <= mid;
        end
      end
      OP_RD_X1: begin
        x0_r <= ax_rdata_r;
      end
      OP_DIV_INIT: begin
        // rounded quotient: half the divisor is added to the dividend
        dv_q_r    <= {1'b0, mn, 16'd0} + 49'(md >> 1);
        dv_rem_r  <= '0;
        dv_den_r  <= md;
        dv_cnt_r  <= 6'd48;
        dv_neg_r  <= num[32] ^ den[32];
        dv_zero_r <= (den == '0);
      end
      OP_DIV_STEP: begin
        if (rem_sh >= {1'b0, dv_den_r}) begin
          dv_rem_r <= 32'(rem_sh - {1'b0, dv_den_r});
          dv_q_r   <= {dv_q_r[47:0], 1'b1};
        end else begin
          dv_rem_r <= rem_sh[31:0];
          dv_q_r   <= {dv_q_r[47:0], 1'b0};
        end
        dv_cnt_r <= dv_cnt_r - 1'b1;
      end
      OP_DIV_STORE: begin
        t_mag_r[d_r] <= dv_zero_r ? '0 : dv_q_r;
        t_neg_r[d_r] <= dv_neg_r;
        pos_r[d_r]   <= lo_r;
        zero_r       <= zero_r | dv_zero_r;
        d_r          <= d_r + 1'b1;
      end
      OP_GRID_WR: begin
        j_r <= j_r + 1'b1;
      end
      OP_L_RDB: begin
        a_r <= cs_rdata_r;
      end
      OP_L_DIFF: begin
        ld_mag_r <= dd[32] ? 32'(-dd) : 32'(dd);
        ld_neg_r <= dd[32] ^ (t_neg_r[lv_r] & (t_sel != '0));
      end
      OP_L_MLO: begin
        p_lo_r <= ld_mag_r * t_sel[31:0];
      end
      OP_L_MHI: begin
        p_hi_r <= 49'(ld_mag_r * t_sel[48:32]);
      end
      OP_L_SUM: begin
        over_r <= (prod[80:49] != '0);
        r_r    <= 34'((50'(prod[48:0]) + 50'h8000) >> 16);
      end
      OP_L_FIN: begin
        res_r <= lf_res;
        sat_r <= sat_r | lf_sat;
        if (k_r == 2'((3'd1 << lv_r) - 3'd1)) begin
          lv_r <= lv_r - 1'b1;
          k_r  <= 2'd0;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  logic     out_valid_r;
  gmi_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_data_r.value  <= res_r;
      out_data_r.status <= zero_r ? ST_ZERO : (sat_r ? ST_SAT : ST_OK);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign st.query       = (in_data.func == FUNC_QUERY);
  assign st.dim_zero    = (dims_r == 2'd0);
  assign st.open        = ((hi_r - lo_r) > PW'(1));
  assign st.div_last    = (dv_cnt_r == 6'd0);
  assign st.last_axis   = (d_r == dims_r - 2'd1);
  assign st.last_corner = (j_r == 3'((4'd1 << dims_r) - 4'd1));
  assign st.last_lerp   = (lv_r == 2'd0);
  assign st.out_free    = !out_valid_r || out_ready;

endmodule

`default_nettype wire

### rtl/core/grid_multilinear_interpolator.sv
// Linear, bilinear or trilinear interpolation on a rectilinear grid, signed Q16.16.
// Input channel (in_valid/in_ready/in_data) carries three kinds of item: an axis
// coordinate write, a grid value write and a query. Writes complete in the cycle of
// transfer and give no result. A query gives one result on out_valid/out_ready/out_data.
// Configuration (cfg_we/cfg_index/cfg_data) sets the axis count and the points per
// axis; write it only while no query is in flight.
// One item at a time. A query runs, for each of its D axes, a binary search of the
// coordinates and a division in the one-bit-a-cycle weight divider; it then fetches
// the 2^D corners and blends them, forming each product in low and high halves, in
// the steps read A, read B, difference, multiply low, multiply high, sum and finish
// for each interpolation.
// The result sits in an output register: if the receiver stalls the next item is
// still taken, and only a following query waits before handing over its result.
// Reset (rst_n, synchronous) empties the output and sets one axis of two points;
// both stores keep their contents undefined until written.
// Depends on gmi_pkg, gmi_ctrl and gmi_dp.
`default_nettype none

module grid_multilinear_interpolator #(
  parameter int MAX_AXIS_POINTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gmi_pkg::gmi_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gmi_pkg::gmi_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [gmi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gmi_pkg::*;

  gmi_cmd_t cmd;
  gmi_st_t  st;

  gmi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  gmi_dp #(
    .MAX_AXIS_POINTS (MAX_AXIS_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/core/gmi_checker.sv
// gmi_checker: port-level assertions of the grid interpolator
// bound to grid_multilinear_interpolator; uses gmi_pkg
`default_nettype none

module gmi_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input gmi_pkg::gmi_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input gmi_pkg::gmi_out_t out_data
);
  import gmi_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_SAT ||
                   out_data.status == ST_ZERO))
    else $error("unknown status code");

  // a query transfer always makes the block busy in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func == FUNC_QUERY) |=> !in_ready)
    else $error("query taken without going busy");

endmodule

bind grid_multilinear_interpolator gmi_checker u_gmi_checker (.*);

`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking testbench of grid_multilinear_interpolator
// drives axis, grid and query items over the input channel, predicts every result in place
// depends on gmi_pkg and the grid_multilinear_interpolator rtl
`timescale 1ns / 100ps

module tb_top;
  import gmi_pkg::*;

  localparam logic [1:0] FUNC_NOP  = 2'd3;
  localparam logic [1:0] AXIS_NONE = 2'd3;
  localparam int NPTS = 16;
  localparam int STALL_LIMIT = 20000;
  localparam bit [63:0] PROD_LIM = (64'd1 << 49) - 64'd1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  gmi_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gmi_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DIM;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_multilinear_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow of the block
  int coord_mem[3*NPTS];
  int grid_mem[GRID_DEPTH];
  logic [1:0] sh_dim = 2'd1;
  logic [4:0] sh_pts[3] = '{5'd2, 5'd2, 5'd2};
  bit blend_sat, zero_width;

  gmi_in_t pending_items[$];
  gmi_out_t expected_results[$];
  int send_idle, recv_idle;
  int errors, n_queries, n_writes, n_checked, n_phases;
  int idle_cycles;

  function automatic int unsigned clamp_pts(logic [4:0] p);
    if (p < 2) return 2;
    if (p > NPTS) return NPTS;
    return p;
  endfunction

  function automatic int unsigned locate(int ax, int unsigned n, longint q);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = n - 1;
    if (q <= coord_mem[ax*NPTS]) return 0;
    if (q >= coord_mem[ax*NPTS + n - 1]) return n - 2;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (q < coord_mem[ax*NPTS + mid]) hi = mid; else lo = mid;
    end
    return lo;
  endfunction

  function automatic longint axis_weight(longint q, longint x0, longint x1);
    longint num, den;
    bit [63:0] mn, md, mt;
    num = q - x0;
    den = x1 - x0;
    if (den == 0) begin
      zero_width = 1'b1;
      return 0;
    end
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    mt = ((mn << 16) + md / 2) / md;
    return ((num < 0) != (den < 0)) ? -longint'(mt) : longint'(mt);
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    longint d, s, v;
    bit neg;
    bit [63:0] mt, md, r;
    d = b - a;
    neg = (t < 0) != (d < 0);
    mt = (t < 0) ? -t : t;
    md = (d < 0) ? -d : d;
    if (mt != 0 && md > PROD_LIM / mt) begin
      blend_sat = 1'b1;
      return neg ? -64'sd2147483648 : 64'sd2147483647;
    end
    r = (mt * md + 64'h8000) >> 16;
    s = neg ? -longint'(r) : longint'(r);
    v = a + s;
    if (v > 64'sd2147483647) begin blend_sat = 1'b1; v = 64'sd2147483647; end
    if (v < -64'sd2147483648) begin blend_sat = 1'b1; v = -64'sd2147483648; end
    return v;
  endfunction

  // updates the shadow stores and queues the result of a query
  function automatic void interpolate(gmi_in_t it);
    int unsigned n[3], pos[3], dim, sy, sx, k;
    longint q[3], t[3], c[8];
    bit [31:0] addr;
    gmi_out_t res;
    case (it.func)
      FUNC_AXIS: begin
        if (it.axis != AXIS_NONE && it.index < NPTS) coord_mem[it.axis*NPTS + it.index] = it.data;
      end
      FUNC_GRID: grid_mem[it.index] = it.data;
      FUNC_QUERY: begin
        dim = sh_dim;
        res = '0;
        if (dim != 0) begin
          blend_sat = 1'b0;
          zero_width = 1'b0;
          q[0] = it.query_x;
          q[1] = it.query_y;
          q[2] = it.query_z;
          for (int d = 0; d < 3; d++) begin
            n[d] = clamp_pts(sh_pts[d]);
            pos[d] = 0;
            t[d] = 0;
          end
          for (int d = 0; d < dim; d++) begin
            pos[d] = locate(d, n[d], q[d]);
            t[d] = axis_weight(q[d], coord_mem[d*NPTS + pos[d]], coord_mem[d*NPTS + pos[d] + 1]);
          end
          sy = (dim >= 3) ? n[2] : 1;
          sx = (dim >= 2) ? n[1] * sy : 1;
          for (k = 0; k < 8; k++) begin
            addr = (pos[0] + ((k >> 2) & 1)) * sx;
            if (dim >= 2) addr += (pos[1] + ((k >> 1) & 1)) * sy;
            if (dim >= 3) addr += pos[2] + (k & 1);
            c[k] = grid_mem[addr % GRID_DEPTH];
          end
          for (k = 0; k < 4; k++)
            c[k] = (dim >= 3) ? blend(c[2*k], c[2*k+1], t[2]) : c[2*k];
          for (k = 0; k < 2; k++)
            c[k] = (dim >= 2) ? blend(c[2*k], c[2*k+1], t[1]) : c[2*k];
          res.value = blend(c[0], c[1], t[0]);
          res.status = zero_width ? ST_ZERO : (blend_sat ? ST_SAT : ST_OK);
        end
        expected_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) interpolate(in_data);
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: value %h status %0d",
                   $time, out_data.value, out_data.status);
          errors++;
        end else begin
          if (out_data.value !== expected_results[0].value)
            $display("%0t: value mismatch: expected %h actual %h", $time,
                     expected_results[0].value, out_data.value);
          if (out_data.status !== expected_results[0].status)
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     expected_results[0].status, out_data.status);
          if (out_data !== expected_results[0]) errors++;
          void'(expected_results.pop_front());
          n_checked++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic gmi_in_t make_item(logic [1:0] f, logic [1:0] ax, logic [11:0] idx,
                                        logic [31:0] val);
    gmi_in_t it;
    it.func = f;
    it.axis = ax;
    it.index = idx;
    it.data = val;
    it.query_x = $urandom;
    it.query_y = $urandom;
    it.query_z = $urandom;
    return it;
  endfunction

  function automatic void add_query(logic [31:0] qx, logic [31:0] qy, logic [31:0] qz);
    gmi_in_t it;
    it = make_item(FUNC_QUERY, 2'($urandom), 12'($urandom), $urandom);
    it.query_x = qx;
    it.query_y = qy;
    it.query_z = qz;
    pending_items.push_back(it);
    n_queries++;
  endfunction

  // position on one axis: mostly in and just beyond the span, some on a knot, some anywhere
  function automatic logic [31:0] pick_pos(int ax, int unsigned n);
    longint a, b, lo, hi;
    int sel;
    a = coord_mem[ax*NPTS];
    b = coord_mem[ax*NPTS + n - 1];
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    sel = $urandom_range(99);
    if (sel < 12) return coord_mem[ax*NPTS + $urandom_range(n-1)];
    if (sel < 22) return $urandom;
    lo = lo - (hi - lo) / 4 - 65536;
    hi = hi + (hi - lo) / 4 + 65536;
    return 32'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
  endfunction

  function automatic logic [31:0] grid_sample();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(32'h1FFFFFF)) - 32'sh1000000;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_DIM: sh_dim = val[1:0];
      CFG_PX:  sh_pts[0] = val;
      CFG_PY:  sh_pts[1] = val;
      default: sh_pts[2] = val;
    endcase
  endtask

  // one setting: registers, axis and grid loading, then random traffic
  task automatic run_setting(logic [4:0] dim, logic [4:0] px, logic [4:0] py, logic [4:0] pz,
                             int nq);
    int unsigned n[3], cells, used;
    longint x;
    int sel;
    wait_idle();
    if (n_phases < 3) begin send_idle = 16; recv_idle = 77; end
    else if (n_phases < 6) begin send_idle = 77; recv_idle = 16; end
    else begin send_idle = 0; recv_idle = 0; end
    n_phases++;
    @(posedge clk);
    write_reg(CFG_DIM, dim);
    write_reg(CFG_PX, px);
    write_reg(CFG_PY, py);
    write_reg(CFG_PZ, pz);
    cfg_we <= 1'b0;
    used = (sh_dim == 0) ? 1 : sh_dim;
    cells = 1;
    for (int d = 0; d < 3; d++) begin
      n[d] = clamp_pts(sh_pts[d]);
      if (d < used) cells *= n[d];
      // ascending knots at uneven spacing, now and then unsorted or repeated
      x = $signed($urandom_range(32'h3FFFFFF)) - 32'sh2000000;
      for (int i = 0; i < n[d]; i++) begin
        sel = $urandom_range(19);
        if (sel == 0 && i > 0) ;
        else if (sel == 1) x = x - $urandom_range(32'h1FFFFF);
        else x = x + 1 + $urandom_range(32'h3FFFFF);
        pending_items.push_back(make_item(FUNC_AXIS, 2'(d), 12'(i), 32'(x)));
        n_writes++;
      end
    end
    for (int a = 0; a < cells; a++) begin
      pending_items.push_back(make_item(FUNC_GRID, 2'($urandom), 12'(a), grid_sample()));
      n_writes++;
    end
    for (int i = 0; i < nq; i++) begin
      sel = $urandom_range(99);
      if (sel < 85) begin
        add_query(pick_pos(0, n[0]), pick_pos(1, n[1]), pick_pos(2, n[2]));
      end else if (sel < 89) begin
        pending_items.push_back(make_item(FUNC_GRID, 2'($urandom), $urandom, $urandom));
      end else if (sel < 93) begin
        pending_items.push_back(make_item(FUNC_AXIS, 2'($urandom_range(used-1)),
                                          12'($urandom_range(n[$urandom_range(used-1)]-1)),
                                          32'(coord_mem[0])));
      end else if (sel < 97) begin
        // coordinate writes that the block must drop
        if ($urandom_range(1)) pending_items.push_back(make_item(FUNC_AXIS, AXIS_NONE,
                                                       $urandom, $urandom));
        else pending_items.push_back(make_item(FUNC_AXIS, 2'($urandom_range(2)),
                                               12'($urandom_range(4095, NPTS)), $urandom));
      end else begin
        pending_items.push_back(make_item(FUNC_NOP, 2'($urandom), $urandom, $urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 16;
    recv_idle = 77;

    // directed: reset setting, extremes of the query range and of the fields
    run_setting(5'd1, 5'd2, 5'd2, 5'd2, 4);
    wait_idle();
    add_query(32'h80000000, 0, 0);
    add_query(32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_query(coord_mem[0], 0, 0);
    add_query(coord_mem[1], 0, 0);
    pending_items.push_back(make_item(FUNC_GRID, 2'd3, 12'hFFF, 32'h7FFFFFFF));
    pending_items.push_back(make_item(FUNC_GRID, 2'd0, 12'd1, 32'h80000000));
    pending_items.push_back(make_item(FUNC_GRID, 2'd0, 12'd0, 32'h7FFFFFFF));
    add_query(32'h80000000, 0, 0);
    add_query(32'h7FFFFFFF, 0, 0);
    // zero-width interval with saturating values behind it
    pending_items.push_back(make_item(FUNC_AXIS, 2'd0, 12'd1, 32'(coord_mem[0])));
    add_query(32'h7FFFFFFF, 0, 0);
    // unsorted axis
    pending_items.push_back(make_item(FUNC_AXIS, 2'd0, 12'd1, 32'(coord_mem[0] - 32'h30000)));
    add_query(0, 0, 0);
    add_query(32'h80000000, 0, 0);
    pending_items.push_back(make_item(FUNC_AXIS, AXIS_NONE, 12'hFFF, 32'hFFFFFFFF));
    pending_items.push_back(make_item(FUNC_AXIS, 2'd2, 12'd16, 32'hFFFFFFFF));
    pending_items.push_back(make_item(FUNC_NOP, 2'd3, 12'hFFF, 32'hFFFFFFFF));

    run_setting(5'd0, 5'd2, 5'd2, 5'd2, 20);
    run_setting(5'd3, 5'd2, 5'd2, 5'd2, 50);
    run_setting(5'd2, 5'd16, 5'd16, 5'd2, 40);
    run_setting(5'd3, 5'd3, 5'd4, 5'd5, 50);
    run_setting(5'd1, 5'd31, 5'd0, 5'd1, 40);
    run_setting(5'd2, 5'd0, 5'd17, 5'd31, 50);
    run_setting(5'd3, 5'd16, 5'd2, 5'd16, 50);
    run_setting(5'd3, 5'd3, 5'd3, 5'd3, 50);

    wait_idle();
    repeat (300) @(posedge clk);
    $display("covered %0d settings: %0d queries, %0d store writes, %0d results checked",
             n_phases, n_queries, n_writes, n_checked);
    $display("dimensions 0 to 3, 2 to 16 points per axis, clamped counts and idling both ways");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, expected_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
